### hdl/dctu_pkg.sv
// Package for the 8x8 DCT unit: widths, constant indexes, fixed-point helpers.
// Used by dctu_xform and by the top level dct_8x8_forward_inverse_unit.
package dctu_pkg;

  localparam int BLOCK_SIDE     = 8;
  localparam int BLOCK_ELEMS    = BLOCK_SIDE * BLOCK_SIDE;
  localparam int IDX_W          = $clog2(BLOCK_ELEMS);
  localparam int SIDE_W         = $clog2(BLOCK_SIDE);
  localparam int SAMPLE_W       = 16;
  localparam int STORE_W        = 24;
  localparam int WORK_W         = 32;
  localparam int WORK_FRAC_BITS = 6;
  localparam int DEF_COEF_FRAC  = 14;
  localparam int XFORM_STAGES   = 4;

  typedef logic signed [WORK_W-1:0] work_t;
  typedef work_t vec_t [BLOCK_SIDE];

  localparam int CA = 0, CB = 1, CC = 2, CD = 3, CE = 4, CF = 5, CG = 6;
  localparam int CH = 7, CI = 8, CJ = 9, CK = 10, CQ = 11, CHALF = 12;

  typedef logic signed [63:0] wide_t;

  localparam wide_t CONST_Q30 [13] = '{
    64'sd1489322693, 64'sd296244703, 64'sd1262586814, 64'sd843633538,
    64'sd379625062, 64'sd496004047, 64'sd205451603, 64'sd759250125,
    64'sd1518500250, 64'sd1402911301, 64'sd581104888, 64'sd268435456,
    64'sd536870912
  };

  function automatic wide_t coef_k(input int idx, input int frac);
    return (CONST_Q30[idx] + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
  endfunction

  function automatic work_t m2(input int frac, input int i, input work_t a,
                               input int j, input work_t b);
    wide_t p;
    p = coef_k(i, frac) * wide_t'(a) + coef_k(j, frac) * wide_t'(b);
    p = (p + (64'sd1 <<< (frac - 1))) >>> frac;
    return p[WORK_W-1:0];
  endfunction

  function automatic work_t m1(input int frac, input int i, input work_t a);
    wide_t p;
    p = coef_k(i, frac) * wide_t'(a);
    p = (p + (64'sd1 <<< (frac - 1))) >>> frac;
    return p[WORK_W-1:0];
  endfunction

  function automatic logic signed [STORE_W-1:0] sat_store(input work_t v);
    if (v > work_t'(8388607)) return 24'sh7FFFFF;
    else if (v < -work_t'(8388608)) return 24'sh800000;
    else return v[STORE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] round_out(input work_t v);
    work_t r;
    r = (v + work_t'(1 <<< (WORK_FRAC_BITS - 1))) >>> WORK_FRAC_BITS;
    if (r > work_t'(32767)) return 16'sh7FFF;
    else if (r < -work_t'(32768)) return 16'sh8000;
    else return r[SAMPLE_W-1:0];
  endfunction

endpackage

### hdl/dct_8x8_forward_inverse_unit.sv
// Top level of the 8x8 forward/inverse DCT unit: sequencer and block memories.
// Depends on dctu_pkg and dctu_xform.
//
// Usage: 64 samples of one block enter on the in_ channel in row-major order,
// one transaction each, while in_tready is high. cfg_we writes the direction
// (0 forward, 1 inverse); the value held when the 64th sample is taken applies.
// After the 64th sample the unit runs 8 row passes and then 8 column passes.
// Each pass reads 8 entries of one line, runs them through the butterfly
// pipeline and writes the 8 results back to the transpose memory.
// The 64 results then leave on the out_ channel in row-major order; the next
// result is read from the transpose memory only after the current one is taken.
// in_tready stays low from the 64th sample until the last result is taken.
// When the receiver stalls, the result is held in the output register.
// Reset (synchronous, rst_n low) returns to loading with an empty block and
// the direction at forward; memory contents are not cleared.
module dct_8x8_forward_inverse_unit
  import dctu_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] value_out, [21:16] position, zero fill
  output logic        out_tlast   // last_of_block
);

  typedef enum logic [2:0] {S_LOAD, S_GATHER, S_WAIT, S_SCATTER, S_OUT} state_t;

  state_t state_r;
  logic cfg_dir_r, dir_r, col_r;
  logic [IDX_W-1:0] load_cnt_r;
  logic [SIDE_W-1:0] line_r;
  logic [SIDE_W:0] k_r;
  logic rd_v_r;
  logic [SIDE_W-1:0] rd_k_r;
  logic [IDX_W:0] oc_r;
  logic [IDX_W-1:0] opos_r;
  logic out_valid_r;
  logic [SAMPLE_W-1:0] out_val_r;
  logic [IDX_W-1:0] out_pos_r;
  vec_t s_r, o_r, x_out;
  logic x_out_v, x_in_v;

  logic [SAMPLE_W-1:0] in_mem [BLOCK_ELEMS];
  logic [STORE_W-1:0]  tr_mem [BLOCK_ELEMS];
  logic [SAMPLE_W-1:0] in_rd_r;
  logic [STORE_W-1:0]  tr_rd_r;
  logic in_we, tr_we;
  logic [IDX_W-1:0] in_ra, tr_ra, tr_wa, line_addr;
  logic [STORE_W-1:0] tr_wd;
  logic issue_rd, out_take, out_rd;

  assign in_tready = (state_r == S_LOAD);
  assign in_we = in_tvalid && in_tready;
  assign out_take = out_valid_r && out_tready;
  assign x_in_v = (state_r == S_GATHER) && (k_r == (SIDE_W+1)'(BLOCK_SIDE)) && !rd_v_r;
  assign out_rd = (state_r == S_OUT) && !oc_r[IDX_W] && !out_valid_r && !rd_v_r;

  assign line_addr = col_r ? {k_r[SIDE_W-1:0], line_r} : {line_r, k_r[SIDE_W-1:0]};
  assign in_ra = line_addr;
  assign issue_rd = (state_r == S_GATHER) && !k_r[SIDE_W];
  assign tr_ra = (state_r == S_OUT) ? oc_r[IDX_W-1:0] : line_addr;
  assign tr_we = (state_r == S_SCATTER);
  assign tr_wa = line_addr;
  assign tr_wd = o_r[k_r[SIDE_W-1:0]][STORE_W-1:0];

  always_ff @(posedge clk) begin
    if (in_we) in_mem[load_cnt_r] <= in_tdata;
    in_rd_r <= in_mem[in_ra];
  end

  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_wa] <= tr_wd;
    tr_rd_r <= tr_mem[tr_ra];
  end

  dctu_xform #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .inverse (dir_r),
    .vin     (x_in_v),
    .din     (s_r),
    .vout    (x_out_v),
    .dout    (x_out)
  );

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      if (col_r) s_r[rd_k_r] <= work_t'(signed'(tr_rd_r));
      else s_r[rd_k_r] <= work_t'(signed'(in_rd_r)) <<< WORK_FRAC_BITS;
    end
    if (x_out_v) begin
      for (int i = 0; i < BLOCK_SIDE; i++) begin
        if (col_r) o_r[i] <= work_t'(round_out(x_out[i]));
        else o_r[i] <= work_t'(sat_store(x_out[i]));
      end
    end
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cfg_dir_r   <= 1'b0;
      dir_r       <= 1'b0;
      col_r       <= 1'b0;
      load_cnt_r  <= '0;
      line_r      <= '0;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      rd_k_r      <= '0;
      oc_r        <= '0;
      opos_r      <= '0;
      out_valid_r <= 1'b0;
      out_val_r   <= '0;
      out_pos_r   <= '0;
    end else begin
      if (cfg_we) cfg_dir_r <= cfg_wdata;
      rd_v_r <= issue_rd || out_rd;
      rd_k_r <= k_r[SIDE_W-1:0];
      unique case (state_r)
        S_LOAD: begin
          if (in_we) begin
            load_cnt_r <= load_cnt_r + 1'b1;
            if (load_cnt_r == IDX_W'(BLOCK_ELEMS - 1)) begin
              dir_r   <= cfg_dir_r;
              col_r   <= 1'b0;
              line_r  <= '0;
              k_r     <= '0;
              state_r <= S_GATHER;
            end
          end
        end
        S_GATHER: begin
          if (issue_rd) k_r <= k_r + 1'b1;
          if (x_in_v) state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (x_out_v) begin
            k_r     <= '0;
            state_r <= S_SCATTER;
          end
        end
        S_SCATTER: begin
          if (k_r == (SIDE_W+1)'(BLOCK_SIDE - 1)) begin
            k_r    <= '0;
            line_r <= line_r + 1'b1;
            if (line_r == SIDE_W'(BLOCK_SIDE - 1) && col_r) begin
              oc_r    <= '0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_GATHER;
              if (line_r == SIDE_W'(BLOCK_SIDE - 1)) col_r <= 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_rd) begin
            opos_r <= oc_r[IDX_W-1:0];
            oc_r   <= oc_r + 1'b1;
          end
          if (rd_v_r) begin
            out_valid_r <= 1'b1;
            out_val_r   <= tr_rd_r[SAMPLE_W-1:0];
            out_pos_r   <= opos_r;
          end else if (out_take) begin
            out_valid_r <= 1'b0;
            if (out_pos_r == IDX_W'(BLOCK_ELEMS - 1)) begin
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - SAMPLE_W - IDX_W){1'b0}}, out_pos_r, out_val_r};
  assign out_tlast  = (out_pos_r == IDX_W'(BLOCK_ELEMS - 1));

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while results pending");
  a_xform_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    x_out_v |-> state_r == S_WAIT)
    else $error("butterfly result outside wait state");
  a_single_launch: assert property (@(posedge clk) disable iff (!rst_n)
    x_in_v |=> !x_in_v)
    else $error("butterfly launched twice");

endmodule

### hdl/dctu_xform.sv
// Four-stage pipelined 8-point DCT/IDCT butterfly with factored constants.
// Depends on dctu_pkg; at most one product level per stage, registered in between.
module dctu_xform
  import dctu_pkg::*;
#(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC
) (
  input  logic clk,
  input  logic rst_n,
  input  logic inverse,
  input  logic vin,
  input  vec_t din,
  output logic vout,
  output vec_t dout
);

  vec_t s1_r, s2_r, s3_r, s4_r;
  vec_t s1_nxt, s2_nxt, s3_nxt, s4_nxt;
  logic [XFORM_STAGES-1:0] v_r;
  localparam int F = COEF_FRAC_BITS;

  always_comb begin
    work_t x00, x01, x02, x03, x04, x05, x06, x07;
    x00 = din[0] + din[7]; x01 = din[1] + din[6];
    x02 = din[2] + din[5]; x03 = din[3] + din[4];
    x04 = din[0] - din[7]; x05 = din[1] - din[6];
    x06 = din[2] - din[5]; x07 = din[3] - din[4];
    if (inverse) begin
      s1_nxt[0] = m1(F, CI, din[0]);
      s1_nxt[1] = m2(F, CA, din[1], CB, din[7]);
      s1_nxt[2] = m2(F, CJ, din[2], CK, din[6]);
      s1_nxt[3] = m2(F, CC, din[3], CD, din[5]);
      s1_nxt[4] = m1(F, CI, din[4]);
      s1_nxt[5] = m2(F, CC, din[5], CD, -din[3]);
      s1_nxt[6] = m2(F, CK, din[2], CJ, -din[6]);
      s1_nxt[7] = m2(F, CA, din[7], CB, -din[1]);
    end else begin
      s1_nxt[0] = x00 + x03;
      s1_nxt[1] = x01 + x02;
      s1_nxt[2] = x00 - x03;
      s1_nxt[3] = x01 - x02;
      s1_nxt[4] = m2(F, CA, x04, CB, x07);
      s1_nxt[5] = m2(F, CC, x05, CD, x06);
      s1_nxt[6] = m2(F, CC, x06, CD, -x05);
      s1_nxt[7] = m2(F, CB, x04, CA, -x07);
    end
  end

  always_comb begin
    if (inverse) begin
      s2_nxt[0] = s1_r[0] + s1_r[4];
      s2_nxt[1] = s1_r[1] + s1_r[3];
      s2_nxt[2] = s1_r[0] - s1_r[4];
      s2_nxt[3] = s1_r[1] - s1_r[3];
      s2_nxt[4] = m1(F, CI, s1_r[2]);
      s2_nxt[5] = m1(F, CI, s1_r[6]);
      s2_nxt[6] = s1_r[5] + s1_r[7];
      s2_nxt[7] = s1_r[5] - s1_r[7];
    end else begin
      s2_nxt[0] = m1(F, CE, s1_r[0] + s1_r[1]);
      s2_nxt[1] = m1(F, CE, s1_r[4] + s1_r[5]);
      s2_nxt[2] = m2(F, CF, s1_r[2], CG, s1_r[3]);
      s2_nxt[3] = m1(F, CE, s1_r[4] - s1_r[5]);
      s2_nxt[4] = m1(F, CE, s1_r[0] - s1_r[1]);
      s2_nxt[5] = m1(F, CE, s1_r[6] - s1_r[7]);
      s2_nxt[6] = m2(F, CG, s1_r[2], CF, -s1_r[3]);
      s2_nxt[7] = m1(F, CE, s1_r[6] + s1_r[7]);
    end
  end

  always_comb begin
    s3_nxt = s2_r;
    if (inverse) begin
      s3_nxt[0] = s2_r[0] + s2_r[4];
      s3_nxt[1] = s2_r[1];
      s3_nxt[2] = m1(F, CE, s2_r[0] - s2_r[4]);
      s3_nxt[3] = m1(F, CE, s2_r[2] + s2_r[3]);
      s3_nxt[4] = m1(F, CE, s2_r[2] - s2_r[3]);
      s3_nxt[5] = m1(F, CE, s2_r[5] + s2_r[6]);
      s3_nxt[6] = m1(F, CE, s2_r[5] - s2_r[6]);
      s3_nxt[7] = m1(F, CHALF, s2_r[7]);
    end else begin
      s3_nxt[3] = m1(F, CH, s2_r[3] - s2_r[5]);
      s3_nxt[5] = m1(F, CH, s2_r[3] + s2_r[5]);
    end
  end

  always_comb begin
    s4_nxt = s3_r;
    if (inverse) begin
      s4_nxt[0] = m2(F, CQ, s3_r[0], CE, s3_r[1]);
      s4_nxt[1] = m1(F, CH, s3_r[3] + s3_r[6]);
      s4_nxt[2] = m1(F, CH, s3_r[3] - s3_r[6]);
      s4_nxt[3] = m1(F, CH, s3_r[2] + s3_r[7]);
      s4_nxt[4] = m1(F, CH, s3_r[2] - s3_r[7]);
      s4_nxt[5] = m1(F, CH, s3_r[4] - s3_r[5]);
      s4_nxt[6] = m1(F, CH, s3_r[4] + s3_r[5]);
      s4_nxt[7] = m2(F, CQ, s3_r[0], CE, -s3_r[1]);
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
    s4_r <= s4_nxt;
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[XFORM_STAGES-2:0], vin};
    end
  end

  assign vout = v_r[XFORM_STAGES-1];
  assign dout = s4_r;

endmodule

### test/testbench.sv
// Self-checking testbench for the 8x8 forward/inverse DCT unit.
// It predicts every result of each 64-sample block with its own butterfly model
// and compares the results as they stream out. Depends on dctu_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import dctu_pkg::*;

  localparam int COEF_F = 14;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_INVERSE = 1'b1;
  localparam int IDLE_SENDER = 0, IDLE_RECEIVER = 1, IDLE_NONE = 2;

  typedef longint line_t [8];
  typedef struct packed {
    logic [15:0] value;
    logic [5:0]  pos;
    logic        last;
  } coef_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tlast;

  dct_8x8_forward_inverse_unit u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  const longint coef_q30 [13] = '{
    1489322693, 296244703, 1262586814, 843633538, 379625062, 496004047,
    205451603, 759250125, 1518500250, 1402911301, 581104888, 268435456,
    536870912
  };

  coef_result_t expected_coefs [$];
  logic [15:0] block_samples [64];
  int load_pos = 0;
  logic direction = DIR_FORWARD;
  int idle_mode = IDLE_NONE;
  int error_count = 0;
  int samples_sent = 0;
  int blocks_sent = 0;
  int results_seen = 0;
  int quiet_cycles = 0;

  function automatic longint coef_q(int idx);
    return (coef_q30[idx] + (64'sd1 <<< (29 - COEF_F))) >>> (30 - COEF_F);
  endfunction

  function automatic longint mul_k(int i, longint a);
    return (coef_q(i) * a + (64'sd1 <<< (COEF_F - 1))) >>> COEF_F;
  endfunction

  function automatic longint mul_k2(int i, longint a, int j, longint b);
    return (coef_q(i) * a + coef_q(j) * b + (64'sd1 <<< (COEF_F - 1))) >>> COEF_F;
  endfunction

  function automatic line_t forward_line(line_t s);
    line_t o;
    longint a0, a1, a2, a3, d0, d1, d2, d3, e0, e1, e2, e3, p0, p1, p2, p3, q0, q1;
    a0 = s[0] + s[7]; a1 = s[1] + s[6]; a2 = s[2] + s[5]; a3 = s[3] + s[4];
    d0 = s[0] - s[7]; d1 = s[1] - s[6]; d2 = s[2] - s[5]; d3 = s[3] - s[4];
    e0 = a0 + a3; e1 = a1 + a2; e2 = a0 - a3; e3 = a1 - a2;
    p0 = mul_k2(CA, d0, CB, d3);
    p1 = mul_k2(CC, d1, CD, d2);
    p2 = mul_k2(CC, d2, CD, -d1);
    p3 = mul_k2(CB, d0, CA, -d3);
    q0 = mul_k(CE, p0 - p1);
    q1 = mul_k(CE, p2 - p3);
    o[0] = mul_k(CE, e0 + e1);
    o[1] = mul_k(CE, p0 + p1);
    o[2] = mul_k2(CF, e2, CG, e3);
    o[3] = mul_k(CH, q0 - q1);
    o[4] = mul_k(CE, e0 - e1);
    o[5] = mul_k(CH, q0 + q1);
    o[6] = mul_k2(CG, e2, CF, -e3);
    o[7] = mul_k(CE, p2 + p3);
    return o;
  endfunction

  function automatic line_t inverse_line(line_t s);
    line_t o;
    longint b0, b1, b2, b3, b4, b5, b6, b7, sm, sd, df, dd, r2, t0, t1, t2, r6;
    longint u0, u1, u2, u3, w0, h;
    b0 = mul_k(CI, s[0]);
    b1 = mul_k2(CA, s[1], CB, s[7]);
    b2 = mul_k2(CJ, s[2], CK, s[6]);
    b3 = mul_k2(CC, s[3], CD, s[5]);
    b4 = mul_k(CI, s[4]);
    b5 = mul_k2(CC, s[5], CD, -s[3]);
    b6 = mul_k2(CK, s[2], CJ, -s[6]);
    b7 = mul_k2(CA, s[7], CB, -s[1]);
    sm = b0 + b4; sd = b1 + b3; df = b0 - b4; dd = b1 - b3;
    r2 = mul_k(CI, b2);
    t0 = mul_k(CE, sm - r2);
    t1 = mul_k(CE, df + dd);
    t2 = mul_k(CE, df - dd);
    r6 = mul_k(CI, b6);
    u0 = b5 + b7; u1 = b5 - b7;
    u2 = mul_k(CE, r6 + u0);
    u3 = mul_k(CE, r6 - u0);
    h = mul_k(CHALF, u1);
    w0 = -u3;
    o[0] = mul_k2(CQ, sm + r2, CE, sd);
    o[1] = mul_k(CH, t1 - w0);
    o[2] = mul_k(CH, t1 + w0);
    o[3] = mul_k(CH, t0 + h);
    o[4] = mul_k(CH, t0 - h);
    o[5] = mul_k(CH, t2 - u2);
    o[6] = mul_k(CH, t2 + u2);
    o[7] = mul_k2(CQ, sm + r2, CE, -sd);
    return o;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic predict_block();
    longint mid [64];
    line_t s, o;
    coef_result_t res [64];
    longint v;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) s[c] = longint'($signed(block_samples[r*8+c])) * 64;
      o = direction ? inverse_line(s) : forward_line(s);
      for (int c = 0; c < 8; c++) mid[r*8+c] = clamp(o[c], -8388608, 8388607);
    end
    for (int c = 0; c < 8; c++) begin
      for (int r = 0; r < 8; r++) s[r] = mid[r*8+c];
      o = direction ? inverse_line(s) : forward_line(s);
      for (int r = 0; r < 8; r++) begin
        v = clamp((o[r] + 32) >>> 6, -32768, 32767);
        res[r*8+c].value = v[15:0];
        res[r*8+c].pos = 6'(r*8+c);
        res[r*8+c].last = (r*8+c == 63);
      end
    end
    for (int i = 0; i < 64; i++) expected_coefs.push_back(res[i]);
    blocks_sent++;
  endtask

  task automatic send_sample(input logic [15:0] v);
    while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 17) ||
           (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 53)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    block_samples[load_pos] = v;
    load_pos = (load_pos + 1) % 64;
    if (load_pos == 0) predict_block();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_coefs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    direction = d;
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("MISMATCH at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      case (idle_mode)
        IDLE_SENDER:   out_tready <= ($urandom_range(99) >= 53);
        IDLE_RECEIVER: out_tready <= ($urandom_range(99) >= 17);
        default:       out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    coef_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_coefs.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata, 24'h0);
      end else begin
        want = expected_coefs.pop_front();
        if (out_tdata[15:0] !== want.value)
          report_mismatch("value", 24'(out_tdata[15:0]), 24'(want.value));
        if (out_tdata[21:16] !== want.pos)
          report_mismatch("position", 24'(out_tdata[21:16]), 24'(want.pos));
        if (out_tdata[23:22] !== 2'b00)
          report_mismatch("fill bits", 24'(out_tdata[23:22]), 24'h0);
        if (out_tlast !== want.last)
          report_mismatch("tlast", 24'(out_tlast), 24'(want.last));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_coefs.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_extremes_forward();
    idle_mode = IDLE_SENDER;
    set_direction(DIR_FORWARD);
    for (int i = 0; i < 64; i++) begin
      case (i % 4)
        0: send_sample(16'h7FFF);
        1: send_sample(16'h8000);
        2: send_sample(16'h0000);
        default: send_sample((i & 8) ? 16'hFFFF : 16'h0001);
      endcase
    end
  endtask

  task automatic test_saturation_inverse();
    idle_mode = IDLE_RECEIVER;
    set_direction(DIR_INVERSE);
    for (int i = 0; i < 64; i++) send_sample(((i / 8 + i) % 2) ? 16'h8000 : 16'h7FFF);
  endtask

  task automatic test_random_blocks(input logic d, input int mode, input int nblocks);
    logic [15:0] v;
    idle_mode = mode;
    set_direction(d);
    for (int b = 0; b < nblocks; b++) begin
      for (int i = 0; i < 64; i++) begin
        case ($urandom_range(3))
          0: v = 16'($urandom);
          1: v = 16'($signed($urandom_range(512)) - 256);
          2: v = 16'($signed($urandom_range(4000)) - 2000);
          default: v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        endcase
        send_sample(v);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes_forward();
    test_saturation_inverse();
    test_random_blocks(DIR_FORWARD, IDLE_NONE, 1);
    drain();
    repeat (400) @(posedge clk);
    $display("Sent %0d samples in %0d blocks, forward and inverse, and checked %0d results.",
             samples_sent, blocks_sent, results_seen);
    $display("Handshakes ran with sender idling, receiver stalling, and full rate.");
    if (error_count == 0 && expected_coefs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### dct_8x8_forward_inverse_unit.f
hdl/dctu_pkg.sv
hdl/dctu_xform.sv
hdl/dct_8x8_forward_inverse_unit.sv
test/testbench.sv
